// File: rtl/turtle_3d_interpreter_unit_assert.svh
// Assertion macros used by the turtle interpreter unit.
`ifndef TURTLE_3D_INTERPRETER_UNIT_ASSERT_SVH
`define TURTLE_3D_INTERPRETER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define T3D_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("turtle assertion failed");

// Next-cycle implication checked outside reset.
`define T3D_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("turtle assertion failed");

`endif

// File: rtl/t3d_pkg.sv
package t3d_pkg;

  localparam int unsigned StackDepthDef = 64;

  localparam logic [2:0] ModeDraw    = 3'd0;
  localparam logic [2:0] ModeMove    = 3'd1;
  localparam logic [2:0] ModeRotate  = 3'd2;
  localparam logic [2:0] ModeSave    = 3'd3;
  localparam logic [2:0] ModeRestore = 3'd4;

  localparam logic [1:0] StatDone      = 2'd0;
  localparam logic [1:0] StatDrawn     = 2'd1;
  localparam logic [1:0] StatOverflow  = 2'd2;
  localparam logic [1:0] StatUnderflow = 2'd3;

  localparam logic signed [63:0] Deg360    = 64'sd23592960;
  localparam logic signed [63:0] Deg180    = 64'sd11796480;
  localparam logic signed [63:0] Deg90     = 64'sd5898240;
  localparam logic signed [33:0] CordicOne = 34'sd652032874;

  function automatic logic signed [31:0] atan_deg(input logic [3:0] i);
    logic signed [31:0] v;
    begin
      unique case (i)
        4'd0:  v = 32'sd2949120;
        4'd1:  v = 32'sd1740967;
        4'd2:  v = 32'sd919879;
        4'd3:  v = 32'sd466945;
        4'd4:  v = 32'sd234379;
        4'd5:  v = 32'sd117304;
        4'd6:  v = 32'sd58666;
        4'd7:  v = 32'sd29335;
        4'd8:  v = 32'sd14668;
        4'd9:  v = 32'sd7334;
        4'd10: v = 32'sd3667;
        4'd11: v = 32'sd1833;
        4'd12: v = 32'sd917;
        4'd13: v = 32'sd458;
        4'd14: v = 32'sd229;
        default: v = 32'sd115;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    begin
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      else if (v < -34'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

  // Handshake between sequencer and CORDIC.
  typedef struct packed {
    logic              start;
    logic signed [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] s;
    logic signed [33:0] c;
  } cordic_rsp_t;

endpackage

// File: rtl/turtle_3d_interpreter_unit.sv
// Turtle 3D interpreter: one result transfer per accepted action.
// Draw, rotate, save, unknown modes and empty restore go straight to the output load;
// a popping restore first loads the saved pose; move runs three CORDIC passes,
// six shared multiplies and three position steps, then the output load.
// One item at a time: the next is taken once the result loads, and a stalled
// result holds the input. Reset (rst_n low, synchronous) zeroes pose and stack level;
// stack memory is not cleared.
`include "turtle_3d_interpreter_unit_assert.svh"
module turtle_3d_interpreter_unit #(
  parameter int unsigned STACK_DEPTH = t3d_pkg::StackDepthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[2:0], symbol_id[10:3], move_distance[42:11], delta_x[74:43],
  // delta_y[106:75], delta_z[138:107], zero pad [143:139]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], drawn_symbol[9:2], out_px[41:10], out_py[73:42],
  // out_pz[105:74], out_rx[137:106], out_ry[169:138], out_rz[201:170], pad [207:202]
  output logic [207:0] out_tdata
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_POP   = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } st_t;

  st_t                st_r, st_nxt;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] rot_r [3];
  logic [LW-1:0]      lvl_r;
  logic [7:0]         sym_r;
  logic signed [31:0] dist_r;
  logic [1:0]         stat_r;
  logic [1:0]         ci_r;      // which angle is in the CORDIC
  logic [2:0]         mi_r;      // multiply step
  logic signed [33:0] s_r [3];
  logic signed [33:0] c_r [3];
  logic signed [33:0] syx_r, t_r;
  logic signed [33:0] d_r [3];
  logic               busy_r;
  logic               obuf_v_r;
  logic [207:0]       obuf_r;

  t3d_pkg::cordic_req_t creq;
  t3d_pkg::cordic_rsp_t crsp;
  logic                 mem_we;
  logic [191:0]         mem_rd;
  logic [AW-1:0]        mem_ra, mem_wa;

  t3d_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  t3d_stack_mem #(.STACK_DEPTH(STACK_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa),
    .wdata({rot_r[2], rot_r[1], rot_r[0], pos_r[2], pos_r[1], pos_r[0]}),
    .raddr(mem_ra), .rdata(mem_rd)
  );

  logic in_xfer, out_xfer, obuf_load;
  assign in_tready = (st_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign out_tvalid = obuf_v_r;
  assign out_tdata  = obuf_r;
  // Load the output register once the previous result has drained.
  assign obuf_load = (st_r == S_OUT || st_r == S_WAIT) && (!obuf_v_r || out_tready);

  logic [2:0] in_mode;
  assign in_mode = in_tdata[2:0];

  // Shared multiplier: operands chosen by step index, rounded Q30 product.
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic signed [33:0] mr;
  always_comb begin
    ma = '0; mb = '0;
    unique case (mi_r)
      3'd0: begin ma = s_r[1]; mb = s_r[0]; end
      3'd1: begin ma = c_r[2]; mb = syx_r; end
      3'd2: begin ma = s_r[2]; mb = c_r[0]; end
      3'd3: begin ma = s_r[2]; mb = syx_r; end
      3'd4: begin ma = c_r[2]; mb = c_r[0]; end
      3'd5: begin ma = c_r[1]; mb = s_r[0]; end
      default: begin ma = '0; mb = '0; end
    endcase
    mp = ma * mb + 68'sd536870912;
    mr = 34'(mp >>> 30);
  end

  // Step product: direction times distance, one axis per cycle.
  logic signed [65:0] sp;
  logic signed [33:0] newp;
  always_comb begin
    sp   = 66'(d_r[mi_r[1:0]]) * 66'(dist_r) + 66'sd536870912;
    newp = 34'(pos_r[mi_r[1:0]]) + 34'(sp >>> 30);
  end

  logic push_ok, pop_ok;
  assign push_ok = (lvl_r < LW'(STACK_DEPTH));
  assign pop_ok  = (lvl_r != '0);
  assign mem_we  = in_xfer && (in_mode == t3d_pkg::ModeSave) && push_ok;
  assign mem_wa  = lvl_r[AW-1:0];
  assign mem_ra  = AW'(lvl_r - LW'(1));

  assign creq.start = (st_r == S_CORD) && !busy_r;
  assign creq.angle = rot_r[ci_r];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_mode == t3d_pkg::ModeMove) st_nxt = S_CORD;
          else if (in_mode == t3d_pkg::ModeRestore && pop_ok) st_nxt = S_POP;
          else st_nxt = S_OUT;
        end
      end
      S_CORD: if (crsp.done && ci_r == 2'd2) st_nxt = S_MUL;
      S_MUL:  if (mi_r == 3'd5) st_nxt = S_STEP;
      S_STEP: if (mi_r == 3'd2) st_nxt = S_OUT;
      S_POP:  st_nxt = S_OUT;
      S_OUT:  st_nxt = (obuf_v_r && !out_tready) ? S_WAIT : S_IDLE;
      S_WAIT: if (!obuf_v_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      lvl_r <= '0;
      busy_r <= 1'b0;
      obuf_v_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        rot_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: begin
          if (in_xfer) begin
            sym_r  <= in_tdata[10:3];
            dist_r <= in_tdata[42:11];
            ci_r <= '0; mi_r <= '0; busy_r <= 1'b0;
            unique case (in_mode)
              t3d_pkg::ModeDraw: stat_r <= t3d_pkg::StatDrawn;
              t3d_pkg::ModeRotate: begin
                stat_r <= t3d_pkg::StatDone;
                rot_r[0] <= t3d_pkg::sat32(34'(rot_r[0]) + 34'($signed(in_tdata[74:43])));
                rot_r[1] <= t3d_pkg::sat32(34'(rot_r[1]) + 34'($signed(in_tdata[106:75])));
                rot_r[2] <= t3d_pkg::sat32(34'(rot_r[2]) + 34'($signed(in_tdata[138:107])));
              end
              t3d_pkg::ModeSave: begin
                if (push_ok) begin
                  lvl_r <= lvl_r + LW'(1);
                  stat_r <= t3d_pkg::StatDone;
                end else begin
                  stat_r <= t3d_pkg::StatOverflow;
                end
              end
              t3d_pkg::ModeRestore: begin
                if (pop_ok) begin
                  lvl_r <= lvl_r - LW'(1);
                  stat_r <= t3d_pkg::StatDone;
                end else begin
                  stat_r <= t3d_pkg::StatUnderflow;
                end
              end
              default: stat_r <= t3d_pkg::StatDone;
            endcase
          end
        end
        S_CORD: begin
          if (creq.start) busy_r <= 1'b1;
          if (crsp.done) begin
            s_r[ci_r] <= crsp.s;
            c_r[ci_r] <= crsp.c;
            ci_r <= ci_r + 2'd1;
            busy_r <= 1'b0;
          end
        end
        S_MUL: begin
          // hold t for the subtract/add pairs
          unique case (mi_r)
            3'd0: syx_r <= mr;
            3'd1: t_r <= mr;
            3'd2: d_r[0] <= t_r - mr;
            3'd3: t_r <= mr;
            3'd4: d_r[1] <= t_r + mr;
            3'd5: d_r[2] <= mr;
            default: ;
          endcase
          mi_r <= (mi_r == 3'd5) ? 3'd0 : mi_r + 3'd1;
        end
        S_STEP: begin
          pos_r[mi_r[1:0]] <= t3d_pkg::sat32(newp);
          mi_r <= mi_r + 3'd1;
        end
        S_POP: begin
          pos_r[0] <= mem_rd[31:0];    pos_r[1] <= mem_rd[63:32];
          pos_r[2] <= mem_rd[95:64];   rot_r[0] <= mem_rd[127:96];
          rot_r[1] <= mem_rd[159:128]; rot_r[2] <= mem_rd[191:160];
        end
        default: ;
      endcase
      // Hold the result until it transfers; a new load replaces a drained one.
      if (obuf_load) begin
        obuf_v_r <= 1'b1;
        obuf_r <= {6'd0, rot_r[2], rot_r[1], rot_r[0], pos_r[2], pos_r[1], pos_r[0],
                   (stat_r == t3d_pkg::StatDrawn) ? sym_r : 8'd0, stat_r};
      end else if (out_xfer) begin
        obuf_v_r <= 1'b0;
      end
    end
  end

  `T3D_ASSERT_IMP(a_lvl_bound, clk, rst_n, 1'b1, lvl_r <= LW'(STACK_DEPTH))
  `T3D_ASSERT_IMP(a_cordic_in_move, clk, rst_n, crsp.done, st_r == S_CORD)
  `T3D_ASSERT_NXT(a_push_grows, clk, rst_n, mem_we, lvl_r == $past(lvl_r) + LW'(1))

endmodule

// File: rtl/t3d_cordic.sv
module t3d_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  t3d_pkg::cordic_req_t req,
  output t3d_pkg::cordic_rsp_t rsp
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_FOLD = 4'b0100,
    C_RUN  = 4'b1000
  } cst_t;

  cst_t               st_r, st_nxt;
  logic signed [63:0] a_r, a_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic               neg_r, neg_nxt;
  logic [3:0]         it_r, it_nxt;
  logic               done_r, done_nxt;
  logic signed [63:0] am, af;
  logic signed [12:0] red_hi;
  logic [13:0]        red_hu;
  logic [23:0]        red_prod;
  logic [13:0]        red_qm;
  logic signed [14:0] red_r;
  logic [5:0]         red_m;

  // Residue modulo 360 degrees: 360 degrees is 45 * 2^19 in Q16.16, so keep the
  // low 19 bits and reduce the upper 13 bits modulo 45. The reciprocal 1457/2^16
  // overshoots the quotient by at most one, which one add-back corrects.
  always_comb begin
    red_hi   = a_r[31:19];
    red_hu   = 14'($signed({red_hi[12], red_hi}) + 14'sd4140);
    red_prod = 24'(red_hu) * 24'd1457;
    red_qm   = 14'(red_prod[23:16]) * 14'd45;
    red_r    = $signed({1'b0, red_hu}) - $signed({1'b0, red_qm});
    red_m    = (red_r < 0) ? 6'(red_r + 15'sd45) : 6'(red_r);
  end

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; x_nxt = x_r; y_nxt = y_r;
    neg_nxt = neg_r; it_nxt = it_r; done_nxt = 1'b0; am = a_r; af = a_r;
    unique case (st_r)
      C_IDLE: begin
        if (req.start) begin
          a_nxt = 64'(req.angle);
          st_nxt = C_RED;
          neg_nxt = 1'b0;
        end
      end
      C_RED: begin
        a_nxt = {39'd0, red_m, a_r[18:0]};
        st_nxt = C_FOLD;
      end
      C_FOLD: begin
        // Move into (-180,180], then reflect beyond +-90 and flip the cosine.
        am = (a_r > t3d_pkg::Deg180) ? a_r - t3d_pkg::Deg360 : a_r;
        af = am;
        if (am > t3d_pkg::Deg90) begin
          af = t3d_pkg::Deg180 - am; neg_nxt = 1'b1;
        end else if (am < -t3d_pkg::Deg90) begin
          af = -t3d_pkg::Deg180 - am; neg_nxt = 1'b1;
        end
        a_nxt = af;
        x_nxt = t3d_pkg::CordicOne;
        y_nxt = '0;
        it_nxt = '0;
        st_nxt = C_RUN;
      end
      C_RUN: begin
        if (a_r >= 0) begin
          x_nxt = x_r - (y_r >>> it_r);
          y_nxt = y_r + (x_r >>> it_r);
          a_nxt = a_r - 64'(t3d_pkg::atan_deg(it_r));
        end else begin
          x_nxt = x_r + (y_r >>> it_r);
          y_nxt = y_r - (x_r >>> it_r);
          a_nxt = a_r + 64'(t3d_pkg::atan_deg(it_r));
        end
        it_nxt = it_r + 4'd1;
        if (it_r == 4'd15) begin
          st_nxt = C_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; neg_r <= neg_nxt; it_r <= it_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.s    = y_r;
  assign rsp.c    = neg_r ? -x_r : x_r;

endmodule

// File: rtl/t3d_stack_mem.sv
module t3d_stack_mem #(
  parameter int unsigned STACK_DEPTH = t3d_pkg::StackDepthDef,
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  logic [191:0]   wdata,
  input  logic [AW-1:0]  raddr,
  output logic [191:0]   rdata
);

  logic [191:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

typedef struct {
  logic [2:0]         mode;
  logic [7:0]         sym;
  logic signed [31:0] step_len;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dz;
} action_t;

// Turtle pose tracker: mirrors position, rotation and the saved-pose stack,
// and holds the pose reports still owed by the block.
class turtle_pose_board;
  localparam int StackDepth = t3d_pkg::StackDepthDef;

  int          pos[3];
  int          rot[3];
  int          saved[StackDepth][6];
  int          level;
  logic [207:0] pose_reports[$];
  int          errors;
  int          checked;
  int          overflows;
  int          underflows;

  function new();
    for (int i = 0; i < 3; i++) begin
      pos[i] = 0;
      rot[i] = 0;
    end
    level = 0;
    errors = 0;
    checked = 0;
    overflows = 0;
    underflows = 0;
  endfunction

  static function int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  static function longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Fold the angle into [-90,90] degrees, then 16 CORDIC rotations in Q2.30.
  static function void sin_cos(int angle, output longint s, output longint c);
    longint a, x, y, nx;
    bit     flip;
    longint atan_steps[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                               58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                               229, 115};
    a = longint'(angle) % t3d_pkg::Deg360;
    flip = 0;
    if (a < 0) a += t3d_pkg::Deg360;
    if (a > t3d_pkg::Deg180) a -= t3d_pkg::Deg360;
    if (a > t3d_pkg::Deg90) begin
      a = t3d_pkg::Deg180 - a;
      flip = 1;
    end else if (a < -t3d_pkg::Deg90) begin
      a = -t3d_pkg::Deg180 - a;
      flip = 1;
    end
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= atan_steps[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += atan_steps[i];
      end
      x = nx;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // Apply one accepted action and queue the pose report it causes.
  function void note_action(action_t act);
    logic [1:0]   status;
    logic [7:0]   sym;
    longint       sx, cx, sy, cy, sz, cz, syx, dir[3];
    logic [207:0] report;
    status = t3d_pkg::StatDone;
    sym = 8'd0;
    case (act.mode)
      t3d_pkg::ModeDraw: begin
        status = t3d_pkg::StatDrawn;
        sym = act.sym;
      end
      t3d_pkg::ModeMove: begin
        sin_cos(rot[0], sx, cx);
        sin_cos(rot[1], sy, cy);
        sin_cos(rot[2], sz, cz);
        syx = qmul(sy, sx);
        dir[0] = qmul(cz, syx) - qmul(sz, cx);
        dir[1] = qmul(sz, syx) + qmul(cz, cx);
        dir[2] = qmul(cy, sx);
        for (int i = 0; i < 3; i++)
          pos[i] = clamp32(longint'(pos[i]) + qmul(dir[i], longint'(act.step_len)));
      end
      t3d_pkg::ModeRotate: begin
        rot[0] = clamp32(longint'(rot[0]) + longint'(act.dx));
        rot[1] = clamp32(longint'(rot[1]) + longint'(act.dy));
        rot[2] = clamp32(longint'(rot[2]) + longint'(act.dz));
      end
      t3d_pkg::ModeSave: begin
        if (level >= StackDepth) begin
          status = t3d_pkg::StatOverflow;
          overflows++;
        end else begin
          for (int i = 0; i < 3; i++) begin
            saved[level][i] = pos[i];
            saved[level][3 + i] = rot[i];
          end
          level++;
        end
      end
      t3d_pkg::ModeRestore: begin
        if (level == 0) begin
          status = t3d_pkg::StatUnderflow;
          underflows++;
        end else begin
          level--;
          for (int i = 0; i < 3; i++) begin
            pos[i] = saved[level][i];
            rot[i] = saved[level][3 + i];
          end
        end
      end
      default: ;
    endcase
    report = {6'd0, rot[2], rot[1], rot[0], pos[2], pos[1], pos[0], sym, status};
    pose_reports.insert(pose_reports.size(), report);
  endfunction

  // Compare one pose report against the oldest one owed, field by field.
  function void check_report(logic [207:0] got);
    int    lo[8] = '{0, 2, 10, 42, 74, 106, 138, 170};
    int    wd[8] = '{2, 8, 32, 32, 32, 32, 32, 32};
    string nm[8] = '{"status", "drawn_symbol", "px", "py", "pz", "rx", "ry", "rz"};
    logic [207:0] want;
    logic [31:0]  e, a;
    if (pose_reports.size() == 0) begin
      $display("%0t: unexpected report %h", $time, got);
      errors++;
      return;
    end
    want = pose_reports.pop_front();
    checked++;
    for (int f = 0; f < 8; f++) begin
      e = 32'((want >> lo[f]) & 208'((64'd1 << wd[f]) - 1));
      a = 32'((got >> lo[f]) & 208'((64'd1 << wd[f]) - 1));
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, nm[f], e, a);
        errors++;
      end
    end
  endfunction

  function int pending();
    return pose_reports.size();
  endfunction
endclass

module tb_top;

  localparam logic [2:0] ModeUnknownLo = 3'd5;
  localparam logic [2:0] ModeUnknownHi = 3'd7;
  localparam int         Deg = 65536;       // one degree in Q16.16
  localparam int         NumRandom = 1300;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [207:0] out_tdata;

  turtle_pose_board board;
  bit   calm;           // no idling on either side while set
  bit   hold_off;       // request a long receiver stall
  int   drawn_seen;

  turtle_3d_interpreter_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  // Offer one action; hold it until the transfer happens, then log it.
  task automatic send_action(action_t act);
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, act.dz, act.dy, act.dx, act.step_len, act.sym, act.mode};
    do @(posedge clk); while (!in_tready);
    board.note_action(act);
  endtask

  task automatic send_op(logic [2:0] mode, logic [7:0] sym, int step_len, int dx, int dy,
                         int dz);
    action_t act;
    act.mode     = mode;
    act.sym      = sym;
    act.step_len = step_len;
    act.dx       = dx;
    act.dy       = dy;
    act.dz       = dz;
    send_action(act);
  endtask

  // Mostly moderate angles, sometimes exact quarter turns, sometimes anything.
  function automatic int pick_angle();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return (int'($urandom_range(0, 8)) - 4) * 90 * Deg;
      default: return int'($urandom_range(0, 1440 * Deg)) - 720 * Deg;
    endcase
  endfunction

  function automatic int pick_distance();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(0, 200 * Deg)) - 100 * Deg;
    endcase
  endfunction

  task automatic send_random();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25)
      send_op(t3d_pkg::ModeMove, 8'($urandom), pick_distance(), $urandom, $urandom,
              $urandom);
    else if (roll < 45)
      send_op(t3d_pkg::ModeRotate, 8'($urandom), $urandom, pick_angle(), pick_angle(),
              pick_angle());
    else if (roll < 60)
      send_op(t3d_pkg::ModeDraw, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
    else if (roll < 77)
      send_op(t3d_pkg::ModeSave, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
    else if (roll < 94)
      send_op(t3d_pkg::ModeRestore, 8'($urandom), $urandom, $urandom, $urandom,
              $urandom);
    else
      send_op(3'($urandom_range(ModeUnknownLo, ModeUnknownHi)), 8'($urandom), $urandom,
              $urandom, $urandom, $urandom);
  endtask

  // Result side: check each transfer, stall at random, and honor hold-off.
  initial begin
    int stall_left;
    out_tready <= 1'b0;
    stall_left = 0;
    drawn_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (out_tdata[1:0] == t3d_pkg::StatDrawn) drawn_seen++;
        board.check_report(out_tdata);
      end
      if (hold_off && stall_left == 0) begin
        stall_left = 400;
        hold_off = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin
    int guard;
    board = new();
    calm = 0;
    hold_off = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack restore, symbol extremes, unknown modes,
    // quarter turns, saturation of rotation and position.
    send_op(t3d_pkg::ModeRestore, 8'd0, 0, 0, 0, 0);
    send_op(t3d_pkg::ModeDraw, 8'd0, 0, 0, 0, 0);
    send_op(t3d_pkg::ModeDraw, 8'd255, -1, -1, -1, -1);
    send_op(ModeUnknownLo, 8'd255, -1, -1, -1, -1);
    send_op(ModeUnknownHi, 8'd17, 5, 5, 5, 5);
    send_op(t3d_pkg::ModeMove, 8'd0, Deg, 0, 0, 0);
    send_op(t3d_pkg::ModeRotate, 8'd0, 0, 90 * Deg, 0, 0);
    send_op(t3d_pkg::ModeMove, 8'd0, 3 * Deg, 0, 0, 0);
    send_op(t3d_pkg::ModeRotate, 8'd0, 0, -90 * Deg, 45 * Deg, -30 * Deg);
    send_op(t3d_pkg::ModeSave, 8'd0, 0, 0, 0, 0);
    send_op(t3d_pkg::ModeMove, 8'd0, 32'sh80000000, 0, 0, 0);
    send_op(t3d_pkg::ModeMove, 8'd0, 32'sh80000000, 0, 0, 0);
    send_op(t3d_pkg::ModeRestore, 8'd0, 0, 0, 0, 0);
    send_op(t3d_pkg::ModeRotate, 8'd0, 0, 180 * Deg, -180 * Deg, 270 * Deg);
    send_op(t3d_pkg::ModeMove, 8'd0, 32'sh7fffffff, 0, 0, 0);
    send_op(t3d_pkg::ModeMove, 8'd0, 32'sh7fffffff, 0, 0, 0);
    send_op(t3d_pkg::ModeRotate, 8'd0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_op(t3d_pkg::ModeRotate, 8'd0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_op(t3d_pkg::ModeMove, 8'd0, 7 * Deg, 0, 0, 0);
    send_op(t3d_pkg::ModeRotate, 8'd0, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_op(t3d_pkg::ModeMove, 8'd0, -2 * Deg, 0, 0, 0);
    send_op(t3d_pkg::ModeRestore, 8'd0, 0, 0, 0, 0);

    // Random: fill the stack past full and drain past empty once early and once late,
    // amid mixed traffic with a calm stretch and one long receiver stall.
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 500 && n < 750);
      if (n == 300) hold_off = 1;
      if (n == 100 || n == 1100) begin
        repeat (70) send_op(t3d_pkg::ModeSave, 8'($urandom), $urandom, $urandom,
                            $urandom, $urandom);
        repeat (72) send_op(t3d_pkg::ModeRestore, 8'($urandom), $urandom, $urandom,
                            $urandom, $urandom);
      end
      send_random();
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (board.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);

    $display("Checked %0d pose reports (%0d drawn), %0d overflows, %0d underflows.",
             board.checked, drawn_seen, board.overflows, board.underflows);
    $display("Covered draw, move, rotate, save, restore, unknown modes and saturation.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      if (board.pending() != 0)
        $display("%0t: %0d pose reports never arrived", $time, board.pending());
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: turtle_3d_interpreter_unit.f
+incdir+rtl
rtl/t3d_pkg.sv
rtl/t3d_cordic.sv
rtl/t3d_stack_mem.sv
rtl/turtle_3d_interpreter_unit.sv
test/tb_top.sv
